// File: sv/assert_macros.svh
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: sv/hhpid_pkg.sv
`timescale 1ns / 1ps
package hhpid_pkg;

	localparam int HEADING_W   = 16;
	localparam int ERROR_W     = 16;
	localparam int RATE_W      = 27;
	localparam int SUM_TOP_W   = 32;
	localparam int STEER_W     = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int LOOP_RATE_W = 10;
	localparam int INTEG_W     = 48;
	localparam int MCAND_W     = 48;
	localparam int MPLIER_W    = 16;
	localparam int PROD_W      = MCAND_W + MPLIER_W;
	localparam int TOTAL_W     = 49;
	localparam int STEP_W      = 4;

	typedef logic [HEADING_W-1:0]          heading_t;
	typedef logic signed [ERROR_W-1:0]     error_t;
	typedef logic signed [RATE_W-1:0]      rate_t;
	typedef logic signed [SUM_TOP_W-1:0]   sum_top_t;
	typedef logic signed [STEER_W-1:0]     steer_t;
	typedef logic signed [INTEG_W-1:0]     integ_t;
	typedef logic signed [TOTAL_W-1:0]     total_t;
	typedef logic [CFG_INDEX_W-1:0]        cfg_index_t;

	// Configuration register indexes
	localparam cfg_index_t REG_DECLINATION     = 3'd0;
	localparam cfg_index_t REG_TARGET_HEADING  = 3'd1;
	localparam cfg_index_t REG_GAIN_PROP       = 3'd2;
	localparam cfg_index_t REG_GAIN_RATE       = 3'd3;
	localparam cfg_index_t REG_GAIN_INTEGRAL   = 3'd4;
	localparam cfg_index_t REG_LOOP_RATE_HZ    = 3'd5;
	localparam cfg_index_t REG_LOOP_PERIOD_Q16 = 3'd6;

	// Register defaults
	localparam logic signed [15:0]   DECLINATION_RST     = 16'sd852;
	localparam heading_t             TARGET_HEADING_RST  = 16'd27000;
	localparam logic [15:0]          GAIN_PROP_RST       = 16'd711;
	localparam logic [15:0]          GAIN_RATE_RST       = 16'd0;
	localparam logic [15:0]          GAIN_INTEGRAL_RST   = 16'd0;
	localparam logic [LOOP_RATE_W-1:0] LOOP_RATE_HZ_RST  = 10'd40;
	localparam logic [15:0]          LOOP_PERIOD_Q16_RST = 16'd1638;

	// Circle constants, hundredths of a degree
	localparam heading_t           FULL_U16  = 16'd36000;
	localparam logic [15:0]        HALF_U16  = 16'd18000;
	localparam logic signed [16:0] FULL_S17  = 17'sd36000;
	localparam logic signed [16:0] HALF_S17  = 17'sd18000;
	localparam logic signed [17:0] FULL_S18  = 18'sd36000;
	localparam logic signed [17:0] TWICE_S18 = 18'sd72000;

	localparam integ_t INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam integ_t INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
	localparam steer_t STEER_MAX = {1'b0, {(STEER_W-1){1'b1}}};
	localparam steer_t STEER_MIN = {1'b1, {(STEER_W-1){1'b0}}};

	// Reduce an unsigned heading below a full circle (one fold is enough for 16 bits).
	function automatic heading_t wrap_u16(input heading_t raw);
		return (raw >= FULL_U16) ? heading_t'(raw - FULL_U16) : raw;
	endfunction

	// Add a signed offset to a heading and fold the sum into one circle.
	function automatic heading_t wrap_offset(input heading_t raw, input logic signed [15:0] offs);
		logic signed [17:0] v;
		logic signed [17:0] r;
		v = $signed({2'b00, raw}) + $signed({{2{offs[15]}}, offs});
		if (v < 0)
			r = v + FULL_S18;
		else if (v >= TWICE_S18)
			r = v - TWICE_S18;
		else if (v >= FULL_S18)
			r = v - FULL_S18;
		else
			r = v;
		return r[HEADING_W-1:0];
	endfunction

endpackage

// File: sv/hhpid_in_if.sv
`timescale 1ns / 1ps
interface hhpid_in_if import hhpid_pkg::*; ();
	logic     valid;
	logic     ready;
	heading_t compass_heading;
	heading_t gps_heading;

	modport source (output valid, output compass_heading, output gps_heading, input ready);
	modport sink (input valid, input compass_heading, input gps_heading, output ready);
endinterface

// File: sv/hhpid_out_if.sv
`timescale 1ns / 1ps
interface hhpid_out_if import hhpid_pkg::*; ();
	logic     valid;
	logic     ready;
	heading_t fused_heading;
	error_t   heading_error;
	rate_t    error_rate;
	sum_top_t error_sum_top;
	steer_t   steer_command;

	modport source (output valid, output fused_heading, output heading_error, output error_rate,
		output error_sum_top, output steer_command, input ready);
	modport sink (input valid, input fused_heading, input heading_error, input error_rate,
		input error_sum_top, input steer_command, output ready);
endinterface

// File: sv/heading_hold_pid_controller.sv
// Channel  Dir  Handshake         Payload
// heading  in   valid/ready       compass_heading, gps_heading
// steer    out  valid/ready       fused_heading, heading_error, error_rate,
//                                 error_sum_top, steer_command
// cfg      in   cfg_write strobe  cfg_index (3 bits), cfg_data (16 bits)
//
// A new heading is taken only in the idle state, so one heading is worked at a time.
// The wrap, sort, mid and error states lead into the one shared shift-add multiplier:
// five products of 16 steps each, one multiplier bit per cycle, with a load and a
// writeback state per product, then a final state that fills the result register.
// arst_n restores register defaults and clears the previous error and the integral.
// A stalled result waits in the result register while the next heading is taken and worked;
// that item then holds in the final state until the register frees.
`timescale 1ns / 1ps
module heading_hold_pid_controller import hhpid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  cfg_index_t       cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hhpid_in_if.sink         heading,
	hhpid_out_if.source      steer
);

	// Sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_WRAP = 4'd1;
	localparam logic [3:0] ST_SORT = 4'd2;
	localparam logic [3:0] ST_MID  = 4'd3;
	localparam logic [3:0] ST_ERR  = 4'd4;
	localparam logic [3:0] ST_LOAD = 4'd5;
	localparam logic [3:0] ST_MUL  = 4'd6;
	localparam logic [3:0] ST_POST = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	// Products, in the order they run on the multiplier
	localparam logic [2:0] OP_RATE  = 3'd0;  // (e - previous) * loop rate
	localparam logic [2:0] OP_INTEG = 3'd1;  // e * loop period, into the integral
	localparam logic [2:0] OP_PROP  = 3'd2;  // Kp * e
	localparam logic [2:0] OP_DERIV = 3'd3;  // Kd * rate
	localparam logic [2:0] OP_IGAIN = 3'd4;  // Ki * integral

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MPLIER_W - 1);

	// Configuration registers
	logic signed [15:0]       declination_q;
	heading_t                 target_heading_q;
	logic [15:0]              gain_prop_q;
	logic [15:0]              gain_rate_q;
	logic [15:0]              gain_integral_q;
	logic [LOOP_RATE_W-1:0]   loop_rate_q;
	logic [15:0]              loop_period_q;

	// Sequencer and loop state
	logic [3:0]               state_q;
	logic [2:0]               op_q;
	logic [STEP_W-1:0]        step_q;
	logic                     out_valid_q;
	error_t                   prev_error_q;
	integ_t                   integ_q;

	// Working registers
	heading_t                 compass_q;
	heading_t                 gps_q;
	heading_t                 mag_q;
	heading_t                 gps_wrap_q;
	heading_t                 target_wrap_q;
	heading_t                 lo_q;
	logic signed [16:0]       hi_q;
	heading_t                 mid_q;
	error_t                   error_q;
	rate_t                    rate_q;
	total_t                   total_q;

	// Shift-add multiplier: multiplicand, running high half, multiplier bits shifting out low
	logic signed [MCAND_W-1:0] mcand_q;
	logic signed [MCAND_W:0]   prod_hi_q;
	logic [MPLIER_W-1:0]       prod_lo_q;

	// Result register
	heading_t                 fused_out_q;
	error_t                   error_out_q;
	rate_t                    rate_out_q;
	sum_top_t                 sum_top_out_q;
	steer_t                   steer_out_q;

	logic                     heading_take;
	logic                     out_free;
	logic                     swap;
	heading_t                 lo_sel;
	heading_t                 hi_sel;
	heading_t                 span;
	logic signed [17:0]       mid_sum;
	logic signed [16:0]       mid_half;
	logic signed [16:0]       err_raw;
	error_t                   err_wrapped;
	logic signed [16:0]       err_diff;
	logic signed [MCAND_W-1:0] mcand_sel;
	logic [MPLIER_W-1:0]      mplier_sel;
	logic signed [MCAND_W:0]  addend;
	logic signed [MCAND_W:0]  psum;
	logic [PROD_W-1:0]        product;
	logic signed [INTEG_W:0]  integ_sum;
	integ_t                   integ_next;
	logic [TOTAL_W-9:0]       total_shift;
	steer_t                   steer_val;

	assign heading_take = heading.valid && heading.ready;
	assign out_free     = !out_valid_q || steer.ready;

	assign heading.ready = (state_q == ST_IDLE);

	assign steer.valid         = out_valid_q;
	assign steer.fused_heading = fused_out_q;
	assign steer.heading_error = error_out_q;
	assign steer.error_rate    = rate_out_q;
	assign steer.error_sum_top = sum_top_out_q;
	assign steer.steer_command = steer_out_q;

	// Front end: sort the headings, close the short arc, halve, wrap the error, diff the errors.
	always_comb begin
		swap   = (mag_q > gps_wrap_q);
		lo_sel = swap ? gps_wrap_q : mag_q;
		hi_sel = swap ? mag_q : gps_wrap_q;
		span   = hi_sel - lo_sel;

		// Arithmetic shift gives the floor of the half sum, also below zero
		mid_sum  = $signed({hi_q[16], hi_q}) + $signed({2'b00, lo_q});
		mid_half = mid_sum[17:1];

		err_raw = $signed({1'b0, target_wrap_q}) - $signed({1'b0, mid_q});
		if (err_raw > HALF_S17)
			err_wrapped = error_t'(err_raw - FULL_S17);
		else if (err_raw < -HALF_S17)
			err_wrapped = error_t'(err_raw + FULL_S17);
		else
			err_wrapped = error_t'(err_raw);

		err_diff = $signed({error_q[ERROR_W-1], error_q})
			- $signed({prev_error_q[ERROR_W-1], prev_error_q});
	end

	// Operand select for the next product
	always_comb begin
		mcand_sel  = '0;
		mplier_sel = '0;
		unique case (op_q)
			OP_RATE: begin
				mcand_sel  = {{(MCAND_W-17){err_diff[16]}}, err_diff};
				mplier_sel = {{(MPLIER_W-LOOP_RATE_W){1'b0}}, loop_rate_q};
			end
			OP_INTEG: begin
				mcand_sel  = {{(MCAND_W-ERROR_W){error_q[ERROR_W-1]}}, error_q};
				mplier_sel = loop_period_q;
			end
			OP_PROP: begin
				mcand_sel  = {{(MCAND_W-ERROR_W){error_q[ERROR_W-1]}}, error_q};
				mplier_sel = gain_prop_q;
			end
			OP_DERIV: begin
				mcand_sel  = {{(MCAND_W-RATE_W){rate_q[RATE_W-1]}}, rate_q};
				mplier_sel = gain_rate_q;
			end
			OP_IGAIN: begin
				mcand_sel  = integ_q;
				mplier_sel = gain_integral_q;
			end
			default: begin
				mcand_sel  = '0;
				mplier_sel = '0;
			end
		endcase
	end

	// One multiplier bit per cycle: add the multiplicand if the low bit is set, shift right.
	always_comb begin
		addend  = prod_lo_q[0] ? {mcand_q[MCAND_W-1], mcand_q} : '0;
		psum    = prod_hi_q + addend;
		product = {prod_hi_q[MCAND_W-1:0], prod_lo_q};
	end

	// Integral update with saturation to the 48-bit range
	always_comb begin
		integ_sum = $signed({integ_q[INTEG_W-1], integ_q})
			+ $signed({{(INTEG_W+1-32){product[31]}}, product[31:0]});
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
			integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
		else
			integ_next = integ_sum[INTEG_W-1:0];
	end

	// Drop the 8-bit fraction of the signed Q41.8 total and clamp to 32 bits
	always_comb begin
		total_shift = total_q[TOTAL_W-1:8];
		if ((&total_shift[TOTAL_W-9:STEER_W-1]) || !(|total_shift[TOTAL_W-9:STEER_W-1]))
			steer_val = total_shift[STEER_W-1:0];
		else
			steer_val = total_q[TOTAL_W-1] ? STEER_MIN : STEER_MAX;
	end

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			declination_q    <= DECLINATION_RST;
			target_heading_q <= TARGET_HEADING_RST;
			gain_prop_q      <= GAIN_PROP_RST;
			gain_rate_q      <= GAIN_RATE_RST;
			gain_integral_q  <= GAIN_INTEGRAL_RST;
			loop_rate_q      <= LOOP_RATE_HZ_RST;
			loop_period_q    <= LOOP_PERIOD_Q16_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DECLINATION:     declination_q    <= cfg_data;
				REG_TARGET_HEADING:  target_heading_q <= cfg_data;
				REG_GAIN_PROP:       gain_prop_q      <= cfg_data;
				REG_GAIN_RATE:       gain_rate_q      <= cfg_data;
				REG_GAIN_INTEGRAL:   gain_integral_q  <= cfg_data;
				REG_LOOP_RATE_HZ:    loop_rate_q      <= cfg_data[LOOP_RATE_W-1:0];
				REG_LOOP_PERIOD_Q16: loop_period_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, loop state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_RATE;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			prev_error_q <= '0;
			integ_q      <= '0;
		end else begin
			// Refill the result register from the final state, else free it on its transfer
			if ((state_q == ST_FIN) && out_free)
				out_valid_q <= 1'b1;
			else if (steer.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (heading_take)
						state_q <= ST_WRAP;
				end
				ST_WRAP: state_q <= ST_SORT;
				ST_SORT: state_q <= ST_MID;
				ST_MID:  state_q <= ST_ERR;
				ST_ERR: begin
					op_q    <= OP_RATE;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST)
						state_q <= ST_POST;
				end
				ST_POST: begin
					if (op_q == OP_INTEG)
						integ_q <= integ_next;
					if (op_q == OP_IGAIN) begin
						state_q <= ST_FIN;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_FIN: begin
					// Hold here while an older result still waits
					if (out_free) begin
						prev_error_q <= error_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (heading_take) begin
			compass_q <= heading.compass_heading;
			gps_q     <= heading.gps_heading;
		end

		if (state_q == ST_WRAP) begin
			mag_q         <= wrap_offset(compass_q, declination_q);
			gps_wrap_q    <= wrap_u16(gps_q);
			target_wrap_q <= wrap_u16(target_heading_q);
		end

		if (state_q == ST_SORT) begin
			lo_q <= lo_sel;
			// Long way round: pull the larger heading one circle down
			if (span > HALF_U16)
				hi_q <= $signed({1'b0, hi_sel}) - FULL_S17;
			else
				hi_q <= $signed({1'b0, hi_sel});
		end

		if (state_q == ST_MID) begin
			if (mid_half < 0)
				mid_q <= heading_t'(mid_half + FULL_S17);
			else
				mid_q <= heading_t'(mid_half);
		end

		if (state_q == ST_ERR)
			error_q <= err_wrapped;

		if (state_q == ST_LOAD) begin
			mcand_q   <= mcand_sel;
			prod_hi_q <= '0;
			prod_lo_q <= mplier_sel;
		end

		if (state_q == ST_MUL) begin
			prod_hi_q <= {psum[MCAND_W], psum[MCAND_W:1]};
			prod_lo_q <= {psum[0], prod_lo_q[MPLIER_W-1:1]};
		end

		if (state_q == ST_POST) begin
			case (op_q)
				OP_RATE:  rate_q  <= product[RATE_W-1:0];
				OP_PROP:  total_q <= {{(TOTAL_W-32){product[31]}}, product[31:0]};
				OP_DERIV: total_q <= total_q + $signed(product[TOTAL_W-1:0]);
				OP_IGAIN: total_q <= total_q + $signed({product[PROD_W-1], product[PROD_W-1:16]});
				default: ;
			endcase
		end

		if ((state_q == ST_FIN) && out_free) begin
			fused_out_q   <= mid_q;
			error_out_q   <= error_q;
			rate_out_q    <= rate_q;
			sum_top_out_q <= integ_q[INTEG_W-1:INTEG_W-SUM_TOP_W];
			steer_out_q   <= steer_val;
		end
	end

endmodule

// File: sv/hhpid_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hhpid_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               heading_valid,
	input logic               heading_ready,
	input logic               steer_valid,
	input logic               steer_ready,
	input logic [15:0]        fused_heading,
	input logic signed [15:0] heading_error
);

	`CHK_NEXT(a_steer_hold, clk, arst_n, steer_valid && !steer_ready, steer_valid, "result dropped while stalled")
	`CHK_IMPLY(a_fused_range, clk, arst_n, steer_valid, fused_heading < 16'd36000, "fused heading off circle")
	`CHK_IMPLY(a_error_range, clk, arst_n, steer_valid, (heading_error >= -16'sd18000) && (heading_error <= 16'sd18000), "heading error not wrapped")
	`CHK_NEXT(a_busy_after_take, clk, arst_n, heading_valid && heading_ready, !heading_ready, "heading taken twice in a row")
	`CHK_NEXT(a_no_early_result, clk, arst_n, heading_valid && heading_ready && !steer_valid, !steer_valid, "result right after transfer")

endmodule

bind heading_hold_pid_controller hhpid_chk u_hhpid_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.heading_valid (heading.valid),
	.heading_ready (heading.ready),
	.steer_valid   (steer.valid),
	.steer_ready   (steer.ready),
	.fused_heading (steer.fused_heading),
	.heading_error (steer.heading_error)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import hhpid_pkg::*;

	localparam int         RESET_CYCLES    = 8;
	localparam int         DRAIN_CYCLES    = 120;
	localparam int         CYCLE_LIMIT     = 1000000;
	localparam int         RANDOM_PHASES   = 8;
	localparam int         ITEMS_PER_PHASE = 115;
	localparam int         MAX_REPORTS     = 40;
	localparam int         MAX_GAP         = 140;
	localparam int         MAX_STALL       = 40;
	localparam longint     CIRCLE          = 36000;
	localparam longint     HALF_CIRCLE     = 18000;
	localparam longint     INTEG_HI        = 64'sd140737488355327;
	localparam longint     INTEG_LO        = -INTEG_HI - 1;
	localparam longint     STEER_HI        = 64'sd2147483647;
	localparam longint     STEER_LO        = -STEER_HI - 1;
	// Index with no register behind it; the write must leave everything untouched.
	localparam cfg_index_t REG_UNUSED      = 3'd7;

	typedef struct packed {
		heading_t compass;
		heading_t gps;
	} heading_pair_t;

	typedef struct {
		heading_t fused;
		error_t   err;
		rate_t    rate;
		sum_top_t sum_top;
		steer_t   steer;
	} steer_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hhpid_in_if  heading_ch ();
	hhpid_out_if steer_ch ();

	heading_hold_pid_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.heading   (heading_ch),
		.steer     (steer_ch)
	);

	// Headings waiting to be offered, and steering results still owed by the block.
	heading_pair_t heading_queue[$];
	steer_result_t steer_expect_q[$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	bit steady         = 1'b0;    // no gaps and no stalls while set

	// Controller copy: registers and loop state, kept wide enough that nothing wraps.
	longint declination_m;
	longint target_m;
	longint kp_m;
	longint kd_m;
	longint ki_m;
	longint loop_hz_m;
	longint period_m;
	longint last_error;
	longint error_integral;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Track the loop one tick: fuse, error, rate, integral, then the PID sum.
	function automatic steer_result_t predict_steer(input heading_t compass, input heading_t gps);
		steer_result_t res;
		longint mag, gps_w, lo, hi, mid, err, rate, total, steer;
		gps_w = longint'(gps) % CIRCLE;
		mag = (longint'(compass) + declination_m) % CIRCLE;
		if (mag < 0)
			mag += CIRCLE;
		lo = (mag < gps_w) ? mag : gps_w;
		hi = (mag < gps_w) ? gps_w : mag;
		// Going the short way round across north: pull the larger heading below zero.
		if (hi - lo > HALF_CIRCLE)
			hi -= CIRCLE;
		mid = (hi + lo) >>> 1;
		if (mid < 0)
			mid += CIRCLE;

		err = (target_m % CIRCLE) - mid;
		if (err > HALF_CIRCLE)
			err -= CIRCLE;
		else if (err < -HALF_CIRCLE)
			err += CIRCLE;

		rate = (err - last_error) * loop_hz_m;
		last_error = err;

		error_integral += err * period_m;
		if (error_integral > INTEG_HI)
			error_integral = INTEG_HI;
		else if (error_integral < INTEG_LO)
			error_integral = INTEG_LO;

		total = kp_m * err + kd_m * rate + ((ki_m * error_integral) >>> 16);
		steer = total >>> 8;
		if (steer > STEER_HI)
			steer = STEER_HI;
		else if (steer < STEER_LO)
			steer = STEER_LO;

		res.fused   = heading_t'(mid);
		res.err     = error_t'(err);
		res.rate    = rate_t'(rate);
		res.sum_top = sum_top_t'(error_integral >>> 16);
		res.steer   = steer_t'(steer);
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_REPORTS)
			$display("ERROR at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// Compare one accepted result against the oldest expectation.
	task automatic check_steer(input steer_result_t got);
		steer_result_t want;
		if (steer_expect_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result, fused %0d steer %0d",
				got.fused, got.steer));
			return;
		end
		want = steer_expect_q.pop_front();
		if (got.fused !== want.fused)
			report_mismatch($sformatf("fused_heading %0d, want %0d", got.fused, want.fused));
		if (got.err !== want.err)
			report_mismatch($sformatf("heading_error %0d, want %0d", got.err, want.err));
		if (got.rate !== want.rate)
			report_mismatch($sformatf("error_rate %0d, want %0d", got.rate, want.rate));
		if (got.sum_top !== want.sum_top)
			report_mismatch($sformatf("error_sum_top %0d, want %0d", got.sum_top, want.sum_top));
		if (got.steer !== want.steer)
			report_mismatch($sformatf("steer_command %0d, want %0d", got.steer, want.steer));
	endtask

	// Write one register at the next edge and mirror it into the controller copy.
	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
		REG_DECLINATION:     declination_m = longint'($signed(data));
		REG_TARGET_HEADING:  target_m      = longint'(data);
		REG_GAIN_PROP:       kp_m          = longint'(data);
		REG_GAIN_RATE:       kd_m          = longint'(data);
		REG_GAIN_INTEGRAL:   ki_m          = longint'(data);
		REG_LOOP_RATE_HZ:    loop_hz_m     = longint'(data[LOOP_RATE_W-1:0]);
		REG_LOOP_PERIOD_Q16: period_m      = longint'(data);
		default: ;
		endcase
	endtask

	task automatic apply_config(input logic [15:0] decl, input logic [15:0] target,
		input logic [15:0] kp, input logic [15:0] kd, input logic [15:0] ki,
		input logic [15:0] loop_hz, input logic [15:0] period);
		write_reg(REG_DECLINATION, decl);
		write_reg(REG_TARGET_HEADING, target);
		write_reg(REG_GAIN_PROP, kp);
		write_reg(REG_GAIN_RATE, kd);
		write_reg(REG_GAIN_INTEGRAL, ki);
		write_reg(REG_LOOP_RATE_HZ, loop_hz);
		write_reg(REG_LOOP_PERIOD_Q16, period);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic queue_heading(input heading_t compass, input heading_t gps);
		heading_pair_t pair;
		pair.compass = compass;
		pair.gps     = gps;
		heading_queue.push_back(pair);
	endtask

	// Hold until every heading is taken and every result has come back.
	task automatic wait_idle();
		while (heading_queue.size() != 0 || heading_ch.valid || steer_expect_q.size() != 0)
			@(posedge clk);
	endtask

	// Mostly in range, some raw 16-bit values, otherwise within the given span.
	function automatic logic [15:0] pick_reg(input int lo, input int hi);
		if ($urandom_range(0, 99) < 15)
			return 16'($urandom);
		return 16'(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	// Mix of raw codes, uniform headings and a slow walk so the rate stays small at times.
	function automatic heading_t pick_heading(input heading_t prev);
		int sel;
		int drift;
		sel   = $urandom_range(0, 99);
		drift = int'($urandom_range(0, 800)) - 400;
		if (sel < 10)
			return heading_t'($urandom);
		if (sel < 55)
			return heading_t'($urandom_range(0, 35999));
		return heading_t'((int'(prev) % 36000 + 36000 + drift) % 36000);
	endfunction

	// Sender: offer the head of the heading queue in bursts with random gaps.
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_ch.valid           <= 1'b0;
			heading_ch.compass_heading <= '0;
			heading_ch.gps_heading     <= '0;
			burst_left = $urandom_range(1, 8);
			gap_left   = 0;
		end else begin
			if (heading_ch.valid && heading_ch.ready) begin
				// Transfer taken: predict its result now, with the registers as they stand.
				steer_expect_q.push_back(predict_steer(heading_ch.compass_heading,
					heading_ch.gps_heading));
				void'(heading_queue.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 8);
					gap_left   = steady ? 0 : $urandom_range(0, MAX_GAP);
				end
			end
			if (heading_ch.valid && !heading_ch.ready) begin
				// Hold the offer until the block takes it.
			end else if (gap_left > 0 && !steady) begin
				gap_left--;
				heading_ch.valid <= 1'b0;
			end else if (heading_queue.size() != 0) begin
				gap_left = 0;
				heading_ch.valid           <= 1'b1;
				heading_ch.compass_heading <= heading_queue[0].compass;
				heading_ch.gps_heading     <= heading_queue[0].gps;
			end else begin
				heading_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: check each result transfer, stall in random runs of its own.
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		steer_result_t got;
		if (!arst_n) begin
			steer_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (steer_ch.valid && steer_ch.ready) begin
				got.fused   = steer_ch.fused_heading;
				got.err     = steer_ch.heading_error;
				got.rate    = steer_ch.error_rate;
				got.sum_top = steer_ch.error_sum_top;
				got.steer   = steer_ch.steer_command;
				check_steer(got);
			end
			if (steady) begin
				steer_ch.ready <= 1'b1;
				stall_left = 0;
			end else if (stall_left > 0) begin
				steer_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				steer_ch.ready <= 1'b1;
				if ($urandom_range(0, 99) < 25)
					stall_left = $urandom_range(1, MAX_STALL);
			end
		end
	end

	// Watchdog: a correct run ends far below this.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		heading_t compass_walk;
		heading_t gps_walk;
		cfg_write                  = 1'b0;
		cfg_index                  = REG_DECLINATION;
		cfg_data                   = '0;
		arst_n                     = 1'b0;
		compass_walk               = '0;
		gps_walk                   = '0;

		declination_m  = longint'(DECLINATION_RST);
		target_m       = longint'(TARGET_HEADING_RST);
		kp_m           = longint'(GAIN_PROP_RST);
		kd_m           = longint'(GAIN_RATE_RST);
		ki_m           = longint'(GAIN_INTEGRAL_RST);
		loop_hz_m      = longint'(LOOP_RATE_HZ_RST);
		period_m       = longint'(LOOP_PERIOD_Q16_RST);
		last_error     = 0;
		error_integral = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults out of reset; the first tick sees a previous error of zero.
		queue_heading(16'd0, 16'd0);
		queue_heading(16'd35148, 16'd0);        // compass plus declination lands on 36000
		queue_heading(16'd35999, 16'd35999);    // overflow side of the compass wrap
		queue_heading(16'd65535, 16'd65535);    // raw all-ones codes on both headings
		queue_heading(16'd36000, 16'd36000);    // exactly a full circle on both raw headings
		queue_heading(16'd32768, 16'd32768);
		queue_heading(16'd35148, 16'd18000);    // half circle apart: no fold
		queue_heading(16'd35148, 16'd18001);    // just over half: fold across north
		queue_heading(16'd35153, 16'd35990);    // negative mid-sum, floor halving
		queue_heading(16'd35147, 16'd1);        // mid lands exactly on zero
		queue_heading(16'd8148, 16'd9000);      // error of exactly +18000 stays
		queue_heading(16'd8147, 16'd8999);      // error just over the half circle wraps
		wait_idle();

		// Largest gains, a 1000 Hz loop rate, declination on the negative side.
		apply_config(-16'sd18000, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1000, 16'hFFFF);
		queue_heading(16'd0, 16'd0);            // compass wraps up from below zero
		queue_heading(16'd36000, 16'd18000);    // error of exactly -18000 stays
		queue_heading(16'd36001, 16'd18001);    // error below -18000 wraps, large positive rate
		queue_heading(16'd36000, 16'd18000);    // swing back, large negative rate
		queue_heading(16'd17999, 16'd35999);
		queue_heading(16'd65535, 16'd0);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
			0: apply_config(-16'sd18000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1);
			1: apply_config(16'sd18000, 16'd35999, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1000,
				16'hFFFF);
			2: begin
				// Zero loop rate (upper data bits set) and zero period, out-of-range codes.
				write_reg(REG_UNUSED, 16'($urandom));
				apply_config(16'h8000, 16'hFFFF, pick_reg(0, 65535), pick_reg(0, 65535),
					pick_reg(0, 65535), 16'hFC00, 16'd0);
			end
			3: apply_config(16'h7FFF, 16'd36000, pick_reg(0, 65535), pick_reg(0, 65535),
				pick_reg(0, 65535), 16'hFFFF, pick_reg(1, 65535));
			default: apply_config(pick_reg(-18000, 18000), pick_reg(0, 35999),
				pick_reg(0, 65535), pick_reg(0, 4095), pick_reg(0, 65535), pick_reg(1, 1000),
				pick_reg(1, 65535));
			endcase
			steady = (p % 3 == 2);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				compass_walk = pick_heading(compass_walk);
				gps_walk     = pick_heading(gps_walk);
				queue_heading(compass_walk, gps_walk);
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
